/* rtl/core/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/rtpp_pkg.sv */
package rtpp_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int ROT_FRAC          = 14;
    localparam int CFG_INDEX_W       = 4;
    localparam int CFG_DATA_W        = 64;
    localparam int COORD_W           = 32;

    localparam logic signed [31:0] NORM_MAX = 32'sd1073741823;
    localparam logic signed [31:0] NORM_MIN = -32'sd1073741824;

    localparam logic [47:0] ROT_ROW0_RESET = 48'h0000_0000_4000;
    localparam logic [47:0] ROT_ROW1_RESET = 48'h0000_4000_0000;
    localparam logic [47:0] ROT_ROW2_RESET = 48'h4000_0000_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROT_ROW0    = 4'd0,
        REG_ROT_ROW1    = 4'd1,
        REG_ROT_ROW2    = 4'd2,
        REG_TRANS_XY    = 4'd3,
        REG_TRANS_Z     = 4'd4,
        REG_FOCAL       = 4'd5,
        REG_PRINCIPAL   = 4'd6,
        REG_SKEW        = 4'd7
    } cfg_reg_t;

endpackage

/* rtl/core/rtpp_point_if.sv */
interface rtpp_point_if;
    logic                        valid;
    logic                        ready;
    logic signed [31:0]          point_x;
    logic signed [31:0]          point_y;
    logic signed [31:0]          point_z;
    logic                        last_in;

    modport source (output valid, point_x, point_y, point_z, last_in, input ready);
    modport sink   (input valid, point_x, point_y, point_z, last_in, output ready);
endinterface

/* rtl/core/rtpp_pixel_if.sv */
interface rtpp_pixel_if;
    logic                        valid;
    logic                        ready;
    logic signed [31:0]          pixel_u;
    logic signed [31:0]          pixel_v;
    logic signed [31:0]          point_depth;
    logic                        saturated;
    logic                        last_out;

    modport source (output valid, pixel_u, pixel_v, point_depth, saturated, last_out,
                    input ready);
    modport sink   (input valid, pixel_u, pixel_v, point_depth, saturated, last_out,
                    output ready);
endinterface

/* rtl/core/rtpp_cfg_if.sv */
interface rtpp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [rtpp_pkg::CFG_INDEX_W-1:0]    index;
    logic [rtpp_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/rigid_transform_pinhole_projection.sv */
// Rigid pose plus pinhole projection of one Q16.16 point per transaction. The
// block takes a new point every cycle while its output is not stalled. Its
// depth divide is a restoring divider pipelined one quotient bit per stage
// (31 stages plus an overflow check), framed by two stages of pose arithmetic
// and three of sign, clip and intrinsics. The whole pipeline advances together
// and holds while a finished result is not taken at the output; input ready
// follows from that. Registers are written through the cfg channel, which is
// always ready, and must only change while no point is in flight.
`include "assert_macros.svh"

module rigid_transform_pinhole_projection #(
    parameter int FRAC_BITS = rtpp_pkg::FRAC_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    rtpp_point_if.sink      points,
    rtpp_pixel_if.source    pixels,
    rtpp_cfg_if.sink        cfg
);

    localparam int ACC_W   = 51;
    localparam int CAM_W   = 36;
    localparam int CMP_W   = CAM_W + 32;
    localparam int QB      = 31;
    localparam int STAGES  = QB + 6;
    localparam int PROD_W  = 64;
    localparam int SUM_W   = 66;
    localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    // ---------------- configuration registers ----------------
    logic [47:0] rot0_reg, rot1_reg, rot2_reg;
    logic [63:0] trans_xy_reg, focal_reg, principal_reg;
    logic [31:0] trans_z_reg, skew_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot0_reg      <= rtpp_pkg::ROT_ROW0_RESET;
            rot1_reg      <= rtpp_pkg::ROT_ROW1_RESET;
            rot2_reg      <= rtpp_pkg::ROT_ROW2_RESET;
            trans_xy_reg  <= '0;
            trans_z_reg   <= '0;
            focal_reg     <= {ONE, ONE};
            principal_reg <= '0;
            skew_reg      <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (rtpp_pkg::cfg_reg_t'(cfg.index))
                rtpp_pkg::REG_ROT_ROW0:  rot0_reg      <= cfg.data[47:0];
                rtpp_pkg::REG_ROT_ROW1:  rot1_reg      <= cfg.data[47:0];
                rtpp_pkg::REG_ROT_ROW2:  rot2_reg      <= cfg.data[47:0];
                rtpp_pkg::REG_TRANS_XY:  trans_xy_reg  <= cfg.data;
                rtpp_pkg::REG_TRANS_Z:   trans_z_reg   <= cfg.data[31:0];
                rtpp_pkg::REG_FOCAL:     focal_reg     <= cfg.data;
                rtpp_pkg::REG_PRINCIPAL: principal_reg <= cfg.data;
                rtpp_pkg::REG_SKEW:      skew_reg      <= cfg.data[31:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [STAGES-1:0] valid_reg;
    logic              ce;

    assign ce           = !valid_reg[STAGES-1] || pixels.ready;
    assign points.ready = ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (ce)
            valid_reg <= {valid_reg[STAGES-2:0], points.valid};
    end

    // ---------------- stage 0: rotation products ----------------
    typedef struct packed {
        logic signed [2:0][2:0][47:0] prod;
        logic signed [2:0][31:0]      t;
        logic                         last;
    } s0_t;

    s0_t s0_reg, s0_next;

    always_comb
    begin
        logic [2:0][47:0] rows;
        logic signed [2:0][31:0] p;
        rows = {rot2_reg, rot1_reg, rot0_reg};
        p    = {points.point_z, points.point_y, points.point_x};
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                s0_next.prod[r][c] = $signed(rows[r][16*c +: 16]) * $signed(p[c]);
        s0_next.t[0] = $signed(trans_xy_reg[31:0]);
        s0_next.t[1] = $signed(trans_xy_reg[63:32]);
        s0_next.t[2] = $signed(trans_z_reg);
        s0_next.last = points.last_in;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            s0_reg <= s0_next;
    end

    // ---------------- stage 1: camera coordinates ----------------
    typedef struct packed {
        logic signed [2:0][CAM_W-1:0] cam;
        logic                         last;
    } s1_t;

    s1_t s1_reg, s1_next;

    always_comb
    begin
        logic signed [ACC_W-1:0] acc;
        for (int r = 0; r < 3; r++)
        begin
            acc = (ACC_W'($signed(s0_reg.t[r])) <<< rtpp_pkg::ROT_FRAC)
                + ACC_W'($signed(s0_reg.prod[r][0])) + ACC_W'($signed(s0_reg.prod[r][1]))
                + ACC_W'($signed(s0_reg.prod[r][2]));
            s1_next.cam[r] = CAM_W'(acc >>> rtpp_pkg::ROT_FRAC);
        end
        // zero depth becomes one LSB
        if (s1_next.cam[2] == '0)
            s1_next.cam[2] = CAM_W'(1);
        s1_next.last = s0_reg.last;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            s1_reg <= s1_next;
    end

    // ---------------- stage 2 and divider ----------------
    typedef struct packed {
        logic [CMP_W-1:0]        rx;
        logic [CMP_W-1:0]        ry;
        logic [QB-1:0]           qx;
        logic [QB-1:0]           qy;
        logic [CAM_W-1:0]        d;
        logic                    negx;
        logic                    negy;
        logic                    ovfx;
        logic                    ovfy;
        logic signed [CAM_W-1:0] zc;
        logic                    last;
    } div_t;

    div_t div_reg [0:QB];
    div_t div_next [0:QB];

    always_comb
    begin
        logic [CAM_W-1:0] magx, magy, magd;
        logic [CMP_W-1:0] dtop;
        magx = s1_reg.cam[0][CAM_W-1] ? CAM_W'(-s1_reg.cam[0]) : CAM_W'(s1_reg.cam[0]);
        magy = s1_reg.cam[1][CAM_W-1] ? CAM_W'(-s1_reg.cam[1]) : CAM_W'(s1_reg.cam[1]);
        magd = s1_reg.cam[2][CAM_W-1] ? CAM_W'(-s1_reg.cam[2]) : CAM_W'(s1_reg.cam[2]);
        dtop = CMP_W'(magd) << QB;
        div_next[0].rx   = CMP_W'(magx) << FRAC_BITS;
        div_next[0].ry   = CMP_W'(magy) << FRAC_BITS;
        div_next[0].qx   = '0;
        div_next[0].qy   = '0;
        div_next[0].d    = magd;
        div_next[0].negx = s1_reg.cam[0][CAM_W-1] ^ s1_reg.cam[2][CAM_W-1];
        div_next[0].negy = s1_reg.cam[1][CAM_W-1] ^ s1_reg.cam[2][CAM_W-1];
        // quotient magnitude of 2^31 or more always clips
        div_next[0].ovfx = div_next[0].rx >= dtop;
        div_next[0].ovfy = div_next[0].ry >= dtop;
        div_next[0].zc   = s1_reg.cam[2];
        div_next[0].last = s1_reg.last;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            div_reg[0] <= div_next[0];
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_div
        localparam int K = QB - 1 - j;

        always_comb
        begin
            logic [CMP_W-1:0] dk;
            dk = CMP_W'(div_reg[j].d) << K;
            div_next[j+1] = div_reg[j];
            if (div_reg[j].rx >= dk)
            begin
                div_next[j+1].rx    = div_reg[j].rx - dk;
                div_next[j+1].qx[K] = 1'b1;
            end
            if (div_reg[j].ry >= dk)
            begin
                div_next[j+1].ry    = div_reg[j].ry - dk;
                div_next[j+1].qy[K] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
                div_reg[j+1] <= div_next[j+1];
        end
    end

    // ---------------- sign and clip of normalized coordinates ----------------
    typedef struct packed {
        logic signed [31:0]      xn;
        logic signed [31:0]      yn;
        logic signed [CAM_W-1:0] zc;
        logic                    sat;
        logic                    last;
    } post_t;

    post_t post_reg, post_next;

    function automatic logic [32:0] norm_clip(logic [QB-1:0] q, logic neg, logic ovf);
        logic clip;
        logic [31:0] val;
        if (!neg)
        begin
            clip = ovf || q[QB-1];
            val  = clip ? rtpp_pkg::NORM_MAX : 32'(q);
        end
        else
        begin
            clip = ovf || (q > QB'(32'd1073741824));
            val  = clip ? rtpp_pkg::NORM_MIN : -32'(q);
        end
        return {clip, val};
    endfunction

    always_comb
    begin
        logic [32:0] cx, cy;
        cx = norm_clip(div_reg[QB].qx, div_reg[QB].negx, div_reg[QB].ovfx);
        cy = norm_clip(div_reg[QB].qy, div_reg[QB].negy, div_reg[QB].ovfy);
        post_next.xn   = $signed(cx[31:0]);
        post_next.yn   = $signed(cy[31:0]);
        post_next.sat  = cx[32] | cy[32];
        post_next.zc   = div_reg[QB].zc;
        post_next.last = div_reg[QB].last;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            post_reg <= post_next;
    end

    // ---------------- intrinsics products ----------------
    typedef struct packed {
        logic signed [PROD_W-1:0] pu;
        logic signed [PROD_W-1:0] pk;
        logic signed [PROD_W-1:0] pv;
        logic signed [CAM_W-1:0]  zc;
        logic                     sat;
        logic                     last;
    } mul_t;

    mul_t mul_reg, mul_next;

    always_comb
    begin
        mul_next.pu   = $signed(focal_reg[31:0]) * post_reg.xn;
        mul_next.pk   = $signed(skew_reg) * post_reg.yn;
        mul_next.pv   = $signed(focal_reg[63:32]) * post_reg.yn;
        mul_next.zc   = post_reg.zc;
        mul_next.sat  = post_reg.sat;
        mul_next.last = post_reg.last;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            mul_reg <= mul_next;
    end

    // ---------------- pixel sums and output register ----------------
    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] depth;
        logic               sat;
        logic               last;
    } out_t;

    out_t out_reg, out_next;

    localparam logic signed [SUM_W-1:0] S32_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] S32_MIN = SUM_W'(-64'sd2147483648);
    localparam logic signed [CAM_W-1:0] D32_MAX = CAM_W'(64'sd2147483647);
    localparam logic signed [CAM_W-1:0] D32_MIN = CAM_W'(-64'sd2147483648);

    always_comb
    begin
        logic signed [SUM_W-1:0] su, sv;
        logic cu, cv, cd;
        su = (SUM_W'(mul_reg.pu) + SUM_W'(mul_reg.pk)
             + (SUM_W'($signed(principal_reg[31:0])) <<< FRAC_BITS)) >>> FRAC_BITS;
        sv = (SUM_W'(mul_reg.pv)
             + (SUM_W'($signed(principal_reg[63:32])) <<< FRAC_BITS)) >>> FRAC_BITS;
        cu = (su > S32_MAX) || (su < S32_MIN);
        cv = (sv > S32_MAX) || (sv < S32_MIN);
        cd = (mul_reg.zc > D32_MAX) || (mul_reg.zc < D32_MIN);
        out_next.u     = cu ? ((su < 0) ? 32'sh8000_0000 : 32'sh7fff_ffff) : 32'(su);
        out_next.v     = cv ? ((sv < 0) ? 32'sh8000_0000 : 32'sh7fff_ffff) : 32'(sv);
        out_next.depth = cd ? ((mul_reg.zc < 0) ? 32'sh8000_0000 : 32'sh7fff_ffff)
                            : 32'(mul_reg.zc);
        out_next.sat   = mul_reg.sat | cu | cv | cd;
        out_next.last  = mul_reg.last;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            out_reg <= out_next;
    end

    assign pixels.valid       = valid_reg[STAGES-1];
    assign pixels.pixel_u     = out_reg.u;
    assign pixels.pixel_v     = out_reg.v;
    assign pixels.point_depth = out_reg.depth;
    assign pixels.saturated   = out_reg.sat;
    assign pixels.last_out    = out_reg.last;

    // ---------------- assertions ----------------
    `ASSERT_IMPLIES(a_stall_blocks_input, clk, rst_n,
        pixels.valid && !pixels.ready, !points.ready)
    `ASSERT_IMPLIES(a_depth_nonzero, clk, rst_n,
        pixels.valid, pixels.point_depth != 32'sd0)
    `ASSERT_ALWAYS(a_cfg_ready, clk, rst_n, cfg.ready)

endmodule

/* sim/rtpp_checker.sv */
`timescale 1ns / 100ps

module rtpp_checker (
    input  logic         clk,
    input  logic         rst_n,
    rtpp_point_if        pts,
    rtpp_pixel_if        pix,
    rtpp_cfg_if          cfg,
    output int           failures,
    output int           pending,
    output int           checked,
    output int           sat_seen
);

    localparam int FB = rtpp_pkg::FRAC_BITS_DEFAULT;

    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] depth;
        logic               sat;
        logic               last;
    } pixel_t;

    pixel_t     pixel_fifo[$];
    logic [63:0] pose_reg[8];

    function automatic logic [63:0] reg_mask(int idx);
        case (idx) inside
            rtpp_pkg::REG_ROT_ROW0, rtpp_pkg::REG_ROT_ROW1, rtpp_pkg::REG_ROT_ROW2:
                return 64'h0000_FFFF_FFFF_FFFF;
            rtpp_pkg::REG_TRANS_Z, rtpp_pkg::REG_SKEW:
                return 64'h0000_0000_FFFF_FFFF;
            default:
                return '1;
        endcase
    endfunction

    function automatic longint cam_axis(logic [63:0] row, longint p0, longint p1,
                                        longint p2, logic [31:0] t);
        longint acc;
        acc = longint'($signed(t)) * (longint'(1) <<< rtpp_pkg::ROT_FRAC);
        acc += longint'($signed(row[15:0])) * p0;
        acc += longint'($signed(row[31:16])) * p1;
        acc += longint'($signed(row[47:32])) * p2;
        return acc >>> rtpp_pkg::ROT_FRAC;
    endfunction

    function automatic longint clamp(longint val, longint lo, longint hi, inout logic flag);
        if (val > hi)
        begin
            flag = 1'b1;
            return hi;
        end
        if (val < lo)
        begin
            flag = 1'b1;
            return lo;
        end
        return val;
    endfunction

    function automatic pixel_t project_point(logic [31:0] x, logic [31:0] y,
                                             logic [31:0] z, logic last);
        longint p0, p1, p2, xc, yc, zc, xn, yn, u, v, one;
        longint fx, fy, cu, cv, sk;
        logic   sat;
        pixel_t r;
        one = longint'(1) <<< FB;
        sat = 1'b0;
        p0 = longint'($signed(x));
        p1 = longint'($signed(y));
        p2 = longint'($signed(z));
        xc = cam_axis(pose_reg[rtpp_pkg::REG_ROT_ROW0], p0, p1, p2,
                      pose_reg[rtpp_pkg::REG_TRANS_XY][31:0]);
        yc = cam_axis(pose_reg[rtpp_pkg::REG_ROT_ROW1], p0, p1, p2,
                      pose_reg[rtpp_pkg::REG_TRANS_XY][63:32]);
        zc = cam_axis(pose_reg[rtpp_pkg::REG_ROT_ROW2], p0, p1, p2,
                      pose_reg[rtpp_pkg::REG_TRANS_Z][31:0]);
        if (zc == 0)
            zc = 1;
        xn = clamp((xc * one) / zc, longint'(rtpp_pkg::NORM_MIN),
                   longint'(rtpp_pkg::NORM_MAX), sat);
        yn = clamp((yc * one) / zc, longint'(rtpp_pkg::NORM_MIN),
                   longint'(rtpp_pkg::NORM_MAX), sat);
        fx = longint'($signed(pose_reg[rtpp_pkg::REG_FOCAL][31:0]));
        fy = longint'($signed(pose_reg[rtpp_pkg::REG_FOCAL][63:32]));
        cu = longint'($signed(pose_reg[rtpp_pkg::REG_PRINCIPAL][31:0]));
        cv = longint'($signed(pose_reg[rtpp_pkg::REG_PRINCIPAL][63:32]));
        sk = longint'($signed(pose_reg[rtpp_pkg::REG_SKEW][31:0]));
        u = (fx * xn + sk * yn + cu * one) >>> FB;
        v = (fy * yn + cv * one) >>> FB;
        u  = clamp(u, -64'sd2147483648, 64'sd2147483647, sat);
        v  = clamp(v, -64'sd2147483648, 64'sd2147483647, sat);
        zc = clamp(zc, -64'sd2147483648, 64'sd2147483647, sat);
        r.u     = u[31:0];
        r.v     = v[31:0];
        r.depth = zc[31:0];
        r.sat   = sat;
        r.last  = last;
        return r;
    endfunction

    assign pending = pixel_fifo.size();

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t e;
        if (!rst_n)
        begin
            pose_reg[rtpp_pkg::REG_ROT_ROW0]  <= 64'(rtpp_pkg::ROT_ROW0_RESET);
            pose_reg[rtpp_pkg::REG_ROT_ROW1]  <= 64'(rtpp_pkg::ROT_ROW1_RESET);
            pose_reg[rtpp_pkg::REG_ROT_ROW2]  <= 64'(rtpp_pkg::ROT_ROW2_RESET);
            pose_reg[rtpp_pkg::REG_TRANS_XY]  <= '0;
            pose_reg[rtpp_pkg::REG_TRANS_Z]   <= '0;
            pose_reg[rtpp_pkg::REG_FOCAL]     <= {32'h0001_0000, 32'h0001_0000};
            pose_reg[rtpp_pkg::REG_PRINCIPAL] <= '0;
            pose_reg[rtpp_pkg::REG_SKEW]      <= '0;
            pixel_fifo.delete();
            failures = 0;
            checked  = 0;
            sat_seen = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready && cfg.index < 8)
                pose_reg[cfg.index[2:0]] <= cfg.data & reg_mask(int'(cfg.index));
            if (pts.valid && pts.ready)
                pixel_fifo.push_back(project_point(pts.point_x, pts.point_y, pts.point_z,
                                                   pts.last_in));
            if (pix.valid && pix.ready)
            begin
                if (pixel_fifo.size() == 0)
                begin
                    $error("pixel transaction with no point outstanding");
                    failures++;
                end
                else
                begin
                    e = pixel_fifo.pop_front();
                    checked++;
                    if (e.sat)
                        sat_seen++;
                    if (pix.pixel_u !== e.u)
                    begin
                        $error("pixel_u: expected %0d, got %0d", e.u, pix.pixel_u);
                        failures++;
                    end
                    if (pix.pixel_v !== e.v)
                    begin
                        $error("pixel_v: expected %0d, got %0d", e.v, pix.pixel_v);
                        failures++;
                    end
                    if (pix.point_depth !== e.depth)
                    begin
                        $error("point_depth: expected %0d, got %0d", e.depth,
                               pix.point_depth);
                        failures++;
                    end
                    if (pix.saturated !== e.sat)
                    begin
                        $error("saturated: expected %0b, got %0b", e.sat, pix.saturated);
                        failures++;
                    end
                    if (pix.last_out !== e.last)
                    begin
                        $error("last_out: expected %0b, got %0b", e.last, pix.last_out);
                        failures++;
                    end
                end
            end
        end
    end
endmodule

/* sim/tb_rigid_transform_pinhole_projection.sv */
`timescale 1ns / 100ps

module tb_rigid_transform_pinhole_projection;

    localparam logic [rtpp_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 4'd11;
    localparam int PIPE_LAT    = 45;
    localparam int CYCLE_LIMIT = 1000000;

    logic clk;
    logic rst_n;
    int   failures, pending, checked, sat_seen;
    int   sent, cfg_writes, cycles;
    int   stall_cycles;
    bit   quiet;

    rtpp_point_if pts();
    rtpp_pixel_if pix();
    rtpp_cfg_if   cfg();

    rigid_transform_pinhole_projection dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (pts.sink),
        .pixels (pix.source),
        .cfg    (cfg.sink)
    );

    rtpp_checker chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .pts      (pts),
        .pix      (pix),
        .cfg      (cfg),
        .failures (failures),
        .pending  (pending),
        .checked  (checked),
        .sat_seen (sat_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** rigid_transform_pinhole_projection: FAILED **");
            $finish;
        end
    end

    // output side: random back-pressure, plus long hold-offs on request
    initial
    begin
        int gap_left;
        gap_left = 0;
        pix.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_cycles > 0)
            begin
                pix.ready <= 1'b0;
                stall_cycles--;
            end
            else if (gap_left > 0)
            begin
                pix.ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                pix.ready <= 1'b1;
                if (!quiet && $urandom_range(7) == 0)
                    gap_left = ($urandom_range(9) == 0) ? $urandom_range(60, 15)
                                                        : $urandom_range(3, 1);
            end
        end
    end

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
        int gap;
        pts.valid   <= 1'b1;
        pts.point_x <= x;
        pts.point_y <= y;
        pts.point_z <= z;
        pts.last_in <= last;
        do
            @(posedge clk);
        while (!pts.ready);
        sent++;
        gap = 0;
        if (!quiet)
        begin
            case ($urandom_range(19)) inside
                0:       gap = $urandom_range(50, 10);
                [1:5]:   gap = $urandom_range(3, 1);
                default: gap = 0;
            endcase
        end
        if (gap > 0)
        begin
            pts.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_point();
        logic [31:0] x, y, z;
        x = $urandom;
        y = $urandom;
        z = $urandom;
        case ($urandom_range(9)) inside
            [0:2]:
            begin
                // plain in-range scene points in front of the camera
                x = $signed($urandom_range(8388608)) - 4194304;
                y = $signed($urandom_range(8388608)) - 4194304;
                z = $urandom_range(16777216, 65536);
            end
            [3:4]:
            begin
                x = $signed($urandom_range(131072)) - 65536;
                y = $signed($urandom_range(131072)) - 65536;
                z = $signed($urandom_range(6)) - 3;
            end
            5:
            begin
                x = $signed($urandom_range(2000000)) - 1000000;
                z = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end
            default: ;
        endcase
        send_point(x, y, z, 1'($urandom_range(1)));
    endtask

    task automatic write_reg(logic [rtpp_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] d);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg_writes++;
    endtask

    task automatic drain();
        pts.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (PIPE_LAT) @(posedge clk);
    endtask

    // arguments are columns 0, 1 and 2; junk above the row width
    function automatic logic [63:0] rot_row(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        return {16'($urandom_range(65535)), c, b, a};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic program_pose(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                                logic [63:0] txy, logic [31:0] tz, logic [63:0] focal,
                                logic [63:0] pp, logic [31:0] sk);
        drain();
        write_reg(rtpp_pkg::REG_ROT_ROW0, r0);
        write_reg(rtpp_pkg::REG_ROT_ROW1, r1);
        write_reg(rtpp_pkg::REG_ROT_ROW2, r2);
        write_reg(rtpp_pkg::REG_TRANS_XY, txy);
        write_reg(rtpp_pkg::REG_TRANS_Z, {$urandom, tz});
        write_reg(rtpp_pkg::REG_FOCAL, focal);
        write_reg(rtpp_pkg::REG_PRINCIPAL, pp);
        write_reg(rtpp_pkg::REG_SKEW, {$urandom, sk});
        write_reg(REG_UNMAPPED, rand64());
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_burst(int n);
        repeat (n) send_random_point();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        stall_cycles = 0;
        quiet        = 1'b0;
        sent         = 0;
        cfg_writes   = 0;
        cycles       = 0;
        pts.valid    = 1'b0;
        pts.point_x  = '0;
        pts.point_y  = '0;
        pts.point_z  = '0;
        pts.last_in  = 1'b0;
        cfg.valid    = 1'b0;
        cfg.index    = '0;
        cfg.data     = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset pose: identity, unit focal lengths
        send_point(32'h0, 32'h0, 32'h0, 1'b0);             // zero depth clamp
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0, 1'b1);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 1'b0);
        send_point(32'h0003_0000, 32'h0005_0000, 32'hFFFE_0000, 1'b1);
        send_point(32'h0, 32'h0, 32'h0000_0001, 1'b0);
        send_point(32'h0000_4000, 32'h0000_2000, 32'h0001_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 1'b1);
        send_point(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1'b0);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1);

        // random pose; receiver holds off for a long stretch mid-phase
        program_pose(rand64(), rand64(), rand64(), rand64(), $urandom, rand64(), rand64(),
                     $urandom);
        random_burst(150);
        stall_cycles = 300;
        random_burst(150);

        // positive extremes
        program_pose(rot_row(16'h7FFF, 16'h7FFF, 16'h7FFF),
                     rot_row(16'h7FFF, 16'h7FFF, 16'h7FFF),
                     rot_row(16'h7FFF, 16'h7FFF, 16'h7FFF),
                     64'h7FFF_FFFF_7FFF_FFFF, 32'h7FFF_FFFF, 64'h7FFF_FFFF_7FFF_FFFF,
                     64'h7FFF_FFFF_7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        random_burst(150);

        // negative extremes
        program_pose(rot_row(16'h8000, 16'h8000, 16'h8000),
                     rot_row(16'h8000, 16'h8000, 16'h8000),
                     rot_row(16'h8000, 16'h8000, 16'h8000),
                     64'h8000_0000_8000_0000, 32'h8000_0000, 64'h8000_0000_8000_0000,
                     64'h8000_0000_8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        random_burst(150);

        // typical camera, near-identity pose; part of it with no idling at all
        program_pose(rot_row(16'(16'h3FF0 + $urandom_range(31)),
                             16'($urandom_range(255) - 128),
                             16'($urandom_range(255) - 128)),
                     rot_row(16'($urandom_range(255) - 128),
                             16'(16'h3FF0 + $urandom_range(31)),
                             16'($urandom_range(255) - 128)),
                     rot_row(16'($urandom_range(255) - 128),
                             16'($urandom_range(255) - 128),
                             16'(16'h3FF0 + $urandom_range(31))),
                     {32'hFFFE_8000, 32'h0001_4000}, 32'h0005_0000,
                     {32'd500 << 16, 32'd520 << 16}, {32'd240 << 16, 32'd320 << 16},
                     32'h0000_0100);
        random_burst(200);
        quiet = 1'b1;
        random_burst(200);
        quiet = 1'b0;

        // degenerate pose: no rotation, so depth is tz alone (zero, then clamped)
        program_pose(rot_row(16'h0, 16'h0, 16'h0), rot_row(16'h0, 16'h0, 16'h0),
                     rot_row(16'h0, 16'h0, 16'h0), rand64(), 32'h0, rand64(), rand64(),
                     $urandom);
        random_burst(100);

        drain();
        $display("%0d points sent over 6 pose settings, %0d register writes",
                 sent, cfg_writes);
        $display("%0d pixel results checked, %0d of them saturated", checked, sat_seen);
        if (failures == 0)
            $display("** rigid_transform_pinhole_projection: PASSED **");
        else
            $display("** rigid_transform_pinhole_projection: FAILED **");
        $finish;
    end
endmodule
